// ----- design/bfa_pkg.sv -----
// Shared constants, codes and types of the bitmap frame allocator.
package bfa_pkg;

  localparam int NUM_FRAMES       = 32768;
  localparam int FRAME_BYTES_LOG2 = 12;
  localparam int MAP_BITS         = 32;
  localparam int MAP_WORDS        = (NUM_FRAMES + MAP_BITS - 1) / MAP_BITS;
  localparam int WORD_ADDR_W      = $clog2(MAP_WORDS);
  localparam int BIT_W            = $clog2(MAP_BITS);
  localparam int FRAME_W          = $clog2(NUM_FRAMES);
  localparam int ADDR_W           = 32;
  localparam int COUNT_W          = 16;
  localparam int RANGE_W          = 16;

  localparam logic [ADDR_W-1:0]  POOL_BASE_RESET     = 32'h0040_0000;
  localparam logic [RANGE_W-1:0] RESERVE_FIRST_RESET = 16'd0;
  localparam logic [RANGE_W-1:0] RESERVE_LAST_RESET  = 16'd1024;

  // Action codes.
  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE  = 2'd1;
  localparam logic [1:0] ACT_INIT  = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_OUT_OF_MEM  = 2'd1;
  localparam logic [1:0] ST_OUT_OF_POOL = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_POOL_BASE     = 2'd0;
  localparam logic [1:0] REG_RESERVE_FIRST = 2'd1;
  localparam logic [1:0] REG_RESERVE_LAST  = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0]  pool_base;
    logic [RANGE_W-1:0] reserve_first;
    logic [RANGE_W-1:0] reserve_last;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [ADDR_W-1:0] free_address;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ADDR_W-1:0]  frame_address;
    logic [COUNT_W-1:0] used_count;
  } res_t;

endpackage

// ----- design/bitmap_frame_allocator.sv -----
// Top level of the bitmap frame allocator: configuration registers, engine, map and output item.
//
// This block hands out and takes back 4 KiB physical frames from a pool of 32768 frames that
// starts at the address held in the pool_base register. Each input item carries an action:
// allocate returns the base address of the lowest-numbered free frame (status out of frames
// and address 0 when the pool is full), free releases the frame that holds free_address
// (status outside pool when the address lies below pool_base or past the end of the pool,
// in which case nothing changes), and init clears the whole map and marks the frames from
// reserve_first up to but not including reserve_last as used, clipped to the pool. Every
// item yields exactly one result item that also reports the number of used frames. The
// usage map is one bit per frame, kept in a 1024 by 32 bit memory with a registered read.
// After reset the block sweeps that memory to zero, one word a cycle, and accepts no input
// item during the sweep; configuration writes are taken at any time but should only be made
// while no item is in flight. The work per item is set by the single read/write port pair
// of the map: a free inside the pool reads the word holding its frame and clears that frame's
// bit if it is set, an init writes each map word once, and an allocate reads the words from
// word 0 up to the first one that holds a free frame and writes that one back, so it scans
// the whole map when the map is nearly or completely full. A new item is accepted from the
// cycle after the previous result has been handed to the output register, even while that
// result still waits for the consumer.
module bitmap_frame_allocator (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port.
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  // Input items.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // action [1:0], free_address [33:2], zero [39:34]
  // Result items.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata   // status [1:0], frame_address [33:2], used_count [49:34], zero [55:50]
);
  import bfa_pkg::*;

  cfg_t cfg;
  req_t req;
  res_t eng_res;
  res_t out_res;
  logic eng_res_valid;
  logic eng_res_ready;

  logic                   rd_en;
  logic [WORD_ADDR_W-1:0] rd_addr;
  logic [MAP_BITS-1:0]    rd_data;
  logic                   wr_en;
  logic [WORD_ADDR_W-1:0] wr_addr;
  logic [MAP_BITS-1:0]    wr_data;

  // Configuration registers; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pool_base     <= POOL_BASE_RESET;
      cfg.reserve_first <= RESERVE_FIRST_RESET;
      cfg.reserve_last  <= RESERVE_LAST_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_POOL_BASE:     cfg.pool_base     <= cfg_wdata;
        REG_RESERVE_FIRST: cfg.reserve_first <= cfg_wdata[RANGE_W-1:0];
        REG_RESERVE_LAST:  cfg.reserve_last  <= cfg_wdata[RANGE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign req.action       = s_tdata[1:0];
  assign req.free_address = s_tdata[ADDR_W+1:2];

  bfa_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .req       (req),
    .res_valid (eng_res_valid),
    .res_ready (eng_res_ready),
    .res       (eng_res),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  bfa_map_ram u_map (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Output register: the engine goes back to idle once its result is loaded here,
  // so the next item can start while this one waits for the consumer.
  assign eng_res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (eng_res_ready) begin
      m_tvalid <= eng_res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_res_ready && eng_res_valid) begin
      out_res <= eng_res;
    end
  end

  assign m_tdata = {6'b0, out_res.used_count, out_res.frame_address, out_res.status};

endmodule

// ----- design/bfa_map_ram.sv -----
// Usage bitmap memory: one write port and one registered read port.
module bfa_map_ram (
  input  logic                               clk,
  input  logic                               rd_en,
  input  logic [bfa_pkg::WORD_ADDR_W-1:0]    rd_addr,
  output logic [bfa_pkg::MAP_BITS-1:0]       rd_data,
  input  logic                               wr_en,
  input  logic [bfa_pkg::WORD_ADDR_W-1:0]    wr_addr,
  input  logic [bfa_pkg::MAP_BITS-1:0]       wr_data
);
  import bfa_pkg::*;

  logic [MAP_BITS-1:0] mem [MAP_WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/bfa_engine.sv -----
// Sequencer that reads, modifies and writes back the usage bitmap for each action.
module bfa_engine (
  input  logic                                  clk,
  input  logic                                  rst,
  input  bfa_pkg::cfg_t                         cfg,
  input  logic                                  req_valid,
  output logic                                  req_ready,
  input  bfa_pkg::req_t                         req,
  output logic                                  res_valid,
  input  logic                                  res_ready,
  output bfa_pkg::res_t                         res,
  output logic                                  rd_en,
  output logic [bfa_pkg::WORD_ADDR_W-1:0]       rd_addr,
  input  logic [bfa_pkg::MAP_BITS-1:0]          rd_data,
  output logic                                  wr_en,
  output logic [bfa_pkg::WORD_ADDR_W-1:0]       wr_addr,
  output logic [bfa_pkg::MAP_BITS-1:0]          wr_data
);
  import bfa_pkg::*;

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_SCAN    = 3'd2;
  localparam logic [2:0] S_FREE_WR = 3'd3;
  localparam logic [2:0] S_INIT    = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  localparam logic [WORD_ADDR_W-1:0] LAST_WORD = WORD_ADDR_W'(MAP_WORDS - 1);
  localparam logic [RANGE_W-1:0]     FRAMES_MAX = RANGE_W'(NUM_FRAMES);
  localparam int FRAME_TOP = FRAME_BYTES_LOG2 + FRAME_W;

  logic [2:0]             state;
  logic [WORD_ADDR_W-1:0] word_idx;
  logic [FRAME_W-1:0]     target_frame;
  logic [COUNT_W-1:0]     used_total;
  logic [1:0]             status;
  logic [ADDR_W-1:0]      frame_address;

  // Index of the lowest clear bit of a word that is not all ones.
  function automatic logic [BIT_W-1:0] lowest_zero(input logic [MAP_BITS-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = MAP_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

  // Bits of word w that fall inside the half-open frame range [first, last).
  function automatic logic [MAP_BITS-1:0] range_mask(input logic [WORD_ADDR_W-1:0] w,
                                                     input logic [RANGE_W-1:0] first,
                                                     input logic [RANGE_W-1:0] last);
    logic [RANGE_W-BIT_W-1:0] wx;
    logic [MAP_BITS-1:0]      lo_m;
    logic [MAP_BITS-1:0]      hi_m;
    wx = (RANGE_W-BIT_W)'(w);
    if (first[RANGE_W-1:BIT_W] < wx) begin
      lo_m = '1;
    end else if (first[RANGE_W-1:BIT_W] == wx) begin
      lo_m = {MAP_BITS{1'b1}} << first[BIT_W-1:0];
    end else begin
      lo_m = '0;
    end
    if (last[RANGE_W-1:BIT_W] > wx) begin
      hi_m = '1;
    end else if (last[RANGE_W-1:BIT_W] == wx) begin
      hi_m = ~({MAP_BITS{1'b1}} << last[BIT_W-1:0]);
    end else begin
      hi_m = '0;
    end
    return lo_m & hi_m;
  endfunction

  logic                   accept;
  logic [ADDR_W:0]        diff;
  logic                   out_of_pool;
  logic [FRAME_W-1:0]     req_frame;
  logic [RANGE_W-1:0]     clip_last;
  logic [COUNT_W-1:0]     init_count;
  logic                   word_full;
  logic [BIT_W-1:0]       zero_bit;
  logic [FRAME_W-1:0]     found_frame;
  logic                   free_bit;

  assign accept      = req_valid && req_ready;
  assign diff        = {1'b0, req.free_address} - {1'b0, cfg.pool_base};
  assign out_of_pool = diff[ADDR_W] || (|diff[ADDR_W-1:FRAME_TOP]);
  assign req_frame   = diff[FRAME_TOP-1:FRAME_BYTES_LOG2];
  assign clip_last   = (cfg.reserve_last > FRAMES_MAX) ? FRAMES_MAX : cfg.reserve_last;
  assign init_count  = (cfg.reserve_first < clip_last) ?
                       COUNT_W'(clip_last - cfg.reserve_first) : '0;
  assign word_full   = &rd_data;
  assign zero_bit    = lowest_zero(rd_data);
  assign found_frame = {word_idx, zero_bit};
  assign free_bit    = rd_data[target_frame[BIT_W-1:0]];

  assign req_ready         = (state == S_IDLE);
  assign res_valid         = (state == S_DONE);
  assign res.status        = status;
  assign res.frame_address = frame_address;
  assign res.used_count    = used_total;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = word_idx;
    wr_en   = 1'b0;
    wr_addr = word_idx;
    wr_data = '0;
    case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
      end
      S_IDLE: begin
        if (accept && req.action == ACT_ALLOC) begin
          rd_en   = 1'b1;
          rd_addr = '0;
        end else if (accept && req.action == ACT_FREE && !out_of_pool) begin
          rd_en   = 1'b1;
          rd_addr = req_frame[FRAME_W-1:BIT_W];
        end
      end
      S_SCAN: begin
        if (!word_full) begin
          wr_en   = 1'b1;
          wr_data = rd_data | (rd_data + MAP_BITS'(1));
        end else if (word_idx != LAST_WORD) begin
          rd_en   = 1'b1;
          rd_addr = word_idx + WORD_ADDR_W'(1);
        end
      end
      S_FREE_WR: begin
        wr_addr = target_frame[FRAME_W-1:BIT_W];
        if (free_bit) begin
          wr_en   = 1'b1;
          wr_data = rd_data & ~(MAP_BITS'(1) << target_frame[BIT_W-1:0]);
        end
      end
      S_INIT: begin
        wr_en   = 1'b1;
        wr_data = range_mask(word_idx, cfg.reserve_first, clip_last);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      word_idx   <= '0;
      used_total <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (word_idx == LAST_WORD) begin
            state <= S_IDLE;
          end
          word_idx <= word_idx + WORD_ADDR_W'(1);
        end
        S_IDLE: begin
          if (accept) begin
            status        <= ST_OK;
            frame_address <= '0;
            word_idx      <= '0;
            target_frame  <= req_frame;
            case (req.action)
              ACT_ALLOC: begin
                state <= S_SCAN;
              end
              ACT_FREE: begin
                if (out_of_pool) begin
                  status <= ST_OUT_OF_POOL;
                  state  <= S_DONE;
                end else begin
                  state <= S_FREE_WR;
                end
              end
              ACT_INIT: begin
                used_total <= init_count;
                state      <= S_INIT;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (!word_full) begin
            used_total    <= used_total + COUNT_W'(1);
            frame_address <= cfg.pool_base +
                             ADDR_W'({found_frame, {FRAME_BYTES_LOG2{1'b0}}});
            state         <= S_DONE;
          end else if (word_idx == LAST_WORD) begin
            status <= ST_OUT_OF_MEM;
            state  <= S_DONE;
          end else begin
            word_idx <= word_idx + WORD_ADDR_W'(1);
          end
        end
        S_FREE_WR: begin
          if (free_bit) begin
            used_total <= used_total - COUNT_W'(1);
          end
          state <= S_DONE;
        end
        S_INIT: begin
          if (word_idx == LAST_WORD) begin
            state <= S_DONE;
          end
          word_idx <= word_idx + WORD_ADDR_W'(1);
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- verif/tb_bitmap_frame_allocator.sv -----
// Self-checking testbench for the bitmap frame allocator.
`timescale 1ns / 100ps

module tb_bitmap_frame_allocator;
  import bfa_pkg::*;

  // The package names three actions; the fourth code must leave the map alone.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int CYCLE_LIMIT = 3_000_000;
  // A full map or an init keeps the block busy for a whole sweep of the map.
  localparam int END_WAIT    = 1100;
  localparam int LONG_HOLD   = 3000;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_mode_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [31:0] cfg_wdata = 32'd0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = 40'd0;  // action [1:0], free_address [33:2], zero [39:34]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;          // status [1:0], frame_address [33:2], used_count [49:34]

  bitmap_frame_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #10 clk = ~clk;

  // Our own picture of the block: one bit per frame, the running count of used
  // frames and the three configuration registers as last written.
  logic [MAP_BITS-1:0] frame_map [MAP_WORDS];
  int unsigned         frames_in_use = 0;
  logic [ADDR_W-1:0]   pool_base_q   = POOL_BASE_RESET;
  logic [RANGE_W-1:0]  rsv_first_q   = RESERVE_FIRST_RESET;
  logic [RANGE_W-1:0]  rsv_last_q    = RESERVE_LAST_RESET;

  // Results we expect the block to emit, oldest first.
  res_t pending_frame_results[$];
  // Base addresses handed out since the last init; frees mostly draw from here.
  logic [ADDR_W-1:0] granted_frames[$];

  int error_count   = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int oom_expected  = 0;
  int oop_expected  = 0;
  int init_count    = 0;
  int cycle_count   = 0;

  // Sender burst state. With no_gaps set the sender offers back to back.
  bit no_gaps    = 1'b0;
  int burst_left = 0;

  // Receiver state. A test asks for a long hold-off through hold_request and the
  // receiver process counts it down on its own.
  rx_mode_e rx_mode      = RX_OPEN;
  int       rx_left      = 0;
  int       rx_period    = 3;
  int       rx_phase     = 0;
  int       hold_cycles  = 0;
  int       hold_request = 0;

  initial begin
    for (int w = 0; w < MAP_WORDS; w++) frame_map[w] = '0;
  end

  // Lowest free frame, or -1 when every frame is in use.
  function automatic int lowest_unused_frame();
    for (int w = 0; w < MAP_WORDS; w++) begin
      if (frame_map[w] != '1) begin
        for (int b = 0; b < MAP_BITS; b++) begin
          if (!frame_map[w][b]) return w * MAP_BITS + b;
        end
      end
    end
    return -1;
  endfunction

  // Works out the result of one accepted item and updates the map to match.
  task automatic predict_frame_result(input req_t r);
    res_t               res;
    int                 f;
    int unsigned        hi;
    logic [ADDR_W-1:0]  offset;
    logic [ADDR_W-1:0]  frame_no;
    res = '0;
    res.status = ST_OK;
    case (r.action)
      ACT_ALLOC: begin
        f = lowest_unused_frame();
        if (f < 0) begin
          res.status = ST_OUT_OF_MEM;
          oom_expected++;
        end else begin
          frame_map[f / MAP_BITS][f % MAP_BITS] = 1'b1;
          frames_in_use++;
          res.frame_address = pool_base_q + (ADDR_W'(f) << FRAME_BYTES_LOG2);
          granted_frames.push_back(res.frame_address);
        end
      end
      ACT_FREE: begin
        if (r.free_address < pool_base_q) begin
          res.status = ST_OUT_OF_POOL;
        end else begin
          offset   = r.free_address - pool_base_q;
          frame_no = offset >> FRAME_BYTES_LOG2;
          if (frame_no >= NUM_FRAMES) begin
            res.status = ST_OUT_OF_POOL;
          end else if (frame_map[frame_no / MAP_BITS][frame_no % MAP_BITS]) begin
            frame_map[frame_no / MAP_BITS][frame_no % MAP_BITS] = 1'b0;
            frames_in_use--;
          end
        end
        if (res.status == ST_OUT_OF_POOL) oop_expected++;
      end
      ACT_INIT: begin
        for (int w = 0; w < MAP_WORDS; w++) frame_map[w] = '0;
        frames_in_use = 0;
        granted_frames.delete();
        hi = (rsv_last_q > NUM_FRAMES) ? NUM_FRAMES : rsv_last_q;
        for (int unsigned k = rsv_first_q; k < hi; k++) begin
          frame_map[k / MAP_BITS][k % MAP_BITS] = 1'b1;
          frames_in_use++;
        end
        init_count++;
      end
      default: ;  // The unused code changes nothing.
    endcase
    res.used_count = frames_in_use[COUNT_W-1:0];
    pending_frame_results.push_back(res);
  endtask

  // Idle cycles before the next item: random bursts separated by random gaps,
  // with now and then a longer pause.
  function automatic int next_gap();
    if (no_gaps) return 0;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(1, 16);
    if ($urandom_range(0, 7) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 6);
  endfunction

  // Offers one item and returns at the rising edge where it is accepted. The
  // valid stays high after that, so the caller follows up with another item or
  // with stop_sending.
  task automatic send_item(input logic [1:0] action, input logic [ADDR_W-1:0] addr);
    req_t r;
    int   gap;
    r.action       = action;
    r.free_address = addr;
    gap = next_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, r.free_address, r.action};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    predict_frame_result(r);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  // Returns at a rising edge once every expected result has come back.
  task automatic wait_drain();
    stop_sending();
    while (pending_frame_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Register writes are only made while nothing is in flight.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_POOL_BASE:     pool_base_q = value;
      REG_RESERVE_FIRST: rsv_first_q = value[RANGE_W-1:0];
      REG_RESERVE_LAST:  rsv_last_q  = value[RANGE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic configure(input logic [31:0] base, input logic [15:0] first,
                           input logic [15:0] last);
    write_reg(REG_POOL_BASE, base);
    write_reg(REG_RESERVE_FIRST, {16'd0, first});
    write_reg(REG_RESERVE_LAST, {16'd0, last});
  endtask

  function automatic logic [ADDR_W-1:0] frame_addr(input int unsigned f);
    return pool_base_q + (ADDR_W'(f) << FRAME_BYTES_LOG2);
  endfunction

  // Straight after reset with the reset configuration: nothing is reserved yet,
  // so the first allocations start at frame zero. Frees cover a frame already
  // free, addresses just below the pool, just past it, and the last frame.
  task automatic test_reset_defaults();
    send_item(ACT_ALLOC, '0);
    send_item(ACT_ALLOC, 32'hFFFF_FFFF);  // the address is ignored by allocate
    send_item(ACT_FREE, 32'h0040_0FFF);
    send_item(ACT_FREE, 32'h0040_0000);
    send_item(ACT_FREE, 32'h003F_FFFF);
    send_item(ACT_FREE, 32'h0840_0000);
    send_item(ACT_FREE, 32'h083F_FFFF);
    send_item(ACT_UNUSED, 32'hA5A5_5A5A);
    send_item(ACT_INIT, '0);
    send_item(ACT_ALLOC, '0);              // first frame past the reserve, 0x800000
    send_item(ACT_FREE, 32'hFFFF_FFFF);
  endtask

  // Reserve the whole pool so that allocate runs out, give single frames back,
  // then a reserve range clipped at the end of the pool and an empty range.
  task automatic test_full_and_clipped_reserve();
    wait_drain();
    write_reg(REG_RESERVE_FIRST, 32'd0);
    write_reg(REG_RESERVE_LAST, NUM_FRAMES);
    send_item(ACT_INIT, '0);
    send_item(ACT_ALLOC, '0);
    send_item(ACT_FREE, frame_addr(NUM_FRAMES - 1) + 32'h0000_0ABC);
    send_item(ACT_ALLOC, '0);
    send_item(ACT_FREE, frame_addr(0));
    send_item(ACT_ALLOC, '0);
    send_item(ACT_ALLOC, '0);
    wait_drain();
    write_reg(REG_RESERVE_FIRST, 32'd32000);
    write_reg(REG_RESERVE_LAST, 32'h0000_FFFF);
    send_item(ACT_INIT, '0);
    wait_drain();
    write_reg(REG_RESERVE_FIRST, 32'd500);
    write_reg(REG_RESERVE_LAST, 32'd500);
    send_item(ACT_INIT, '0);
    send_item(ACT_ALLOC, '0);
  endtask

  // A pool base near the top of the address space makes frame addresses wrap
  // past zero; such an address then reads as below the pool when freed.
  task automatic test_address_wrap();
    wait_drain();
    configure(32'hFFFF_0000, 16'd0, 16'd20);
    send_item(ACT_INIT, '0);
    send_item(ACT_ALLOC, '0);
    send_item(ACT_FREE, 32'h0000_4000);
    send_item(ACT_FREE, 32'hFFFF_FFFF);
    send_item(ACT_ALLOC, '0);
    wait_drain();
    write_reg(REG_POOL_BASE, 32'h0000_0000);
    send_item(ACT_INIT, '0);
    send_item(ACT_FREE, 32'h0000_0000);
    send_item(ACT_ALLOC, '0);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // quick items, so the output register and the engine fill and s_tready drops.
  task automatic test_output_backpressure();
    wait_drain();
    configure(POOL_BASE_RESET, 16'd0, 16'd64);
    send_item(ACT_INIT, '0);
    wait_drain();
    hold_request = LONG_HOLD;
    no_gaps = 1'b1;
    for (int i = 0; i < 12; i++) begin
      if (i % 3 == 2 && granted_frames.size() != 0)
        send_item(ACT_FREE, granted_frames.pop_front());
      else
        send_item(ACT_ALLOC, '0);
    end
    no_gaps = 1'b0;
    wait_drain();
  endtask

  // One phase of random traffic under a given configuration. Most frees return
  // frames that were handed out; the rest hit random frames of the pool or
  // addresses outside it. Only items that can change the map count.
  task automatic random_phase(input logic [31:0] base, input logic [15:0] first,
                              input logic [15:0] last, input int count, input bit steady);
    int                pick;
    int                idx;
    int                useful;
    int unsigned       f;
    logic [ADDR_W-1:0] addr;
    wait_drain();
    configure(base, first, last);
    no_gaps = steady;
    send_item(ACT_INIT, '0);
    useful = 0;
    while (useful < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45 || (pick < 75 && granted_frames.size() == 0)) begin
        send_item(ACT_ALLOC, $urandom());
        useful++;
      end else if (pick < 75) begin
        idx  = $urandom_range(0, granted_frames.size() - 1);
        addr = granted_frames[idx] + $urandom_range(0, 4095);
        granted_frames.delete(idx);
        send_item(ACT_FREE, addr);
        useful++;
      end else if (pick < 84) begin
        f = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1500)
                                        : $urandom_range(0, NUM_FRAMES - 1);
        send_item(ACT_FREE, frame_addr(f) + $urandom_range(0, 4095));
        useful++;
      end else if (pick < 91) begin
        case ($urandom_range(0, 2))
          0:       addr = pool_base_q - $urandom_range(1, 8192);
          1:       addr = frame_addr(NUM_FRAMES) + $urandom_range(0, 1 << 20);
          default: addr = $urandom();
        endcase
        send_item(ACT_FREE, addr);
      end else if (pick < 96) begin
        send_item(ACT_UNUSED, $urandom());
      end else begin
        send_item(ACT_INIT, $urandom());
        useful++;
      end
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_random_traffic();
    random_phase(POOL_BASE_RESET, 16'd0, 16'd1024, 90, 1'b0);
    random_phase($urandom() & 32'hFFFF_F000, 16'($urandom_range(0, 96)),
                 16'($urandom_range(100, 400)), 90, 1'b1);
    random_phase($urandom(), 16'($urandom_range(0, 40)), 16'($urandom_range(0, 300)),
                 90, 1'b0);
    random_phase(32'hFFFF_8000, 16'd0, 16'd4, 70, 1'b0);
    // Nearly full pool: most allocations scan the whole map.
    random_phase($urandom() & 32'hFFFF_F000, 16'd0, 16'd32760, 50, 1'b0);
    // Reserve range given backwards, so init leaves the map empty.
    random_phase(32'h0000_0000, 16'd300, 16'd100, 80, 1'b0);
  endtask

  // Result checker: every accepted result is compared with the oldest prediction.
  always @(posedge clk) begin
    res_t exp_res;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_frame_results.size() == 0) begin
        $error("result with no item waiting for it: %h", m_tdata);
        error_count++;
      end else begin
        exp_res = pending_frame_results.pop_front();
        if (m_tdata[1:0] !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, m_tdata[1:0]);
          error_count++;
        end
        if (m_tdata[33:2] !== exp_res.frame_address) begin
          $error("frame_address: expected %h, got %h", exp_res.frame_address,
                 m_tdata[33:2]);
          error_count++;
        end
        if (m_tdata[49:34] !== exp_res.used_count) begin
          $error("used_count: expected %0d, got %0d", exp_res.used_count, m_tdata[49:34]);
          error_count++;
        end
      end
    end
  end

  // Receiver: switches between always ready, random stalls and a periodic
  // pattern, and honors a long hold-off when a test asks for one.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_cycles  = hold_request;
      hold_request = 0;
    end
    if (rx_left == 0) begin
      rx_mode   = rx_mode_e'($urandom_range(0, 2));
      rx_left   = $urandom_range(20, 200);
      rx_period = $urandom_range(2, 7);
    end else begin
      rx_left--;
    end
    rx_phase++;
    if (hold_cycles > 0) begin
      hold_cycles--;
      m_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:   m_tready <= 1'b1;
        RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
        default:   m_tready <= ((rx_phase % rx_period) != 0);
      endcase
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_frame_results.size());
      $display("FAIL bitmap_frame_allocator");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // The block clears its map after reset and holds s_tready low meanwhile;
    // the first item simply waits for it.
    test_reset_defaults();
    test_full_and_clipped_reserve();
    test_address_wrap();
    test_output_backpressure();
    test_random_traffic();
    wait_drain();
    repeat (END_WAIT) @(posedge clk);
    $display("Sent %0d items (%0d inits), checked %0d results in %0d cycles.",
             items_sent, init_count, results_seen, cycle_count);
    $display("Expected %0d out-of-frames and %0d outside-pool results.",
             oom_expected, oop_expected);
    if (error_count == 0 && pending_frame_results.size() == 0) begin
      $display("PASS bitmap_frame_allocator");
    end else begin
      $display("FAIL bitmap_frame_allocator");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/bfa_pkg.sv
design/bfa_map_ram.sv
design/bfa_engine.sv
design/bitmap_frame_allocator.sv
verif/tb_bitmap_frame_allocator.sv
